// ===== rtl/epsd_pkg.sv =====
// Package for the edited print stream decoder: escape-state type, character codes
// and the end-of-job pattern check. No dependencies.
`default_nettype none

package epsd_pkg;

    // Widths of the stream payloads.
    localparam int CHAR_W     = 9;
    localparam int OUT_CHAR_W = 8;
    localparam int REPEAT_W   = 7;
    localparam int POS_W      = 4;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // Printer control codes (octal in the printer documentation).
    localparam logic [7:0] CODE_SPACE_ESC = 8'o037;
    localparam logic [7:0] CODE_NLINE_ESC = 8'o013;
    localparam logic [7:0] CODE_FORM_FEED = 8'o014;
    localparam logic [7:0] CODE_NULL      = 8'o000;

    // ASCII characters produced by the escapes.
    localparam logic [7:0] ASCII_SPACE = 8'o040;
    localparam logic [7:0] ASCII_LF    = 8'o012;
    localparam logic [7:0] ASCII_CR    = 8'o015;
    localparam logic [7:0] ASCII_FF    = 8'o014;

    // End-of-job line: 037 014 ddddd 037 005, at least this many characters.
    localparam logic [POS_W-1:0] MIN_EOJ_LEN = 4'd12;
    localparam logic [POS_W-1:0] POS_MAX     = 4'd15;
    localparam logic [CHAR_W-1:0] EOJ_SPACE  = 9'o037;
    localparam logic [CHAR_W-1:0] EOJ_FF     = 9'o014;
    localparam logic [CHAR_W-1:0] EOJ_TAIL   = 9'o005;
    localparam logic [CHAR_W-1:0] DIGIT_LO   = 9'o060;
    localparam logic [CHAR_W-1:0] DIGIT_HI   = 9'o071;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_SPACE = 2'd1,
        ESC_NLINE = 2'd2,
        ESC_SKIP  = 2'd3
    } esc_t;

    // True when a full 9-bit character fits the end-of-job pattern at its position.
    function automatic logic eoj_match(input logic [POS_W-1:0] pos,
                                       input logic [CHAR_W-1:0] c);
        logic ok;
        begin
            case (pos)
                4'd0:    ok = (c == EOJ_SPACE);
                4'd1:    ok = (c == EOJ_FF);
                4'd2, 4'd3, 4'd4, 4'd5, 4'd6:
                         ok = (c >= DIGIT_LO) && (c <= DIGIT_HI);
                4'd7:    ok = (c == EOJ_SPACE);
                4'd8:    ok = (c == EOJ_TAIL);
                default: ok = 1'b1;
            endcase
            return ok;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/edited_print_stream_decoder_unit.sv =====
// Edited print stream decoder top level: expands printer edit codes into ASCII
// characters with repeat counts. Depends on epsd_pkg.
`default_nettype none

// How the block is used:
// The slave channel takes one printer character per transfer, 9 bits in
// s_axis_tdata[8:0], with s_axis_tlast high on the last character of a record.
// The master channel delivers at most one result per input character: an ASCII
// character with its repeat count in m_axis_tdata, the end-of-job flag in
// m_axis_tuser, and m_axis_tlast on the result of a record's last character.
// Characters that print nothing (nulls, escape leaders, the character after a
// form feed, a zero space count) produce no transfer unless they end a record.
// A record end always produces a transfer, possibly with a repeat count of zero.
// A result appears on the master side in the cycle after its character is taken.
// Throughput is one character per cycle while the receiver does not stall; the
// decode is a short combinational step from the accepted character and three
// small state registers into the result register.
// When the receiver stalls, the result register holds its transfer and the
// slave side keeps accepting characters only while the result register is empty
// or is being drained in the same cycle, so nothing is lost or repeated.
// Reset clears the escape state, the record position and the result valid, and
// sets the pattern-match flag, so decoding starts at the head of a record.

module edited_print_stream_decoder_unit (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [epsd_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [8:0] char_in, rest zero
    input  wire                              s_axis_tlast,  // record_end
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [epsd_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // [7:0] out_char, [14:8] repeat_res
    output logic                             m_axis_tuser,  // [0] end_of_job
    output logic                             m_axis_tlast   // record_done
);
    import epsd_pkg::*;

    // Decoder state.
    esc_t             esc_reg,  esc_next;
    logic [POS_W-1:0] pos_reg,  pos_next;
    logic             ok_reg,   ok_next;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_CHAR_W-1:0] out_char_reg,  out_char_next;
    logic [REPEAT_W-1:0]   repeat_reg,    repeat_next;
    logic                  eoj_reg,       eoj_next;
    logic                  done_reg,      done_next;

    logic                  in_fire;
    logic [CHAR_W-1:0]     c9;
    logic [7:0]            ch;
    logic [REPEAT_W-1:0]   cnt;
    logic                  ok_now;
    logic [POS_W-1:0]      pos_now;
    logic [OUT_CHAR_W-1:0] oc;
    logic [REPEAT_W-1:0]   rep;
    esc_t                  esc_after;
    logic                  emit;

    // The result register can take a new result when it is empty or draining.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign c9  = s_axis_tdata[CHAR_W-1:0];
    assign ch  = c9[7:0];
    assign cnt = c9[REPEAT_W-1:0];

    // Pattern tracking uses the full 9-bit character.
    assign ok_now  = ok_reg && eoj_match(pos_reg, c9);
    assign pos_now = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;

    // Character decode.
    always_comb
    begin
        oc        = '0;
        rep       = '0;
        esc_after = ESC_NONE;
        case (esc_reg)
            ESC_SPACE:
            begin
                oc  = ASCII_SPACE;
                rep = cnt;
            end
            ESC_NLINE:
            begin
                if (cnt != '0)
                begin
                    oc  = ASCII_LF;
                    rep = cnt;
                end
                else
                begin
                    oc  = ASCII_CR;
                    rep = REPEAT_W'(1);
                end
            end
            ESC_SKIP:
            begin
                esc_after = ESC_NONE;
            end
            default:
            begin
                if (ch == CODE_SPACE_ESC)
                begin
                    esc_after = ESC_SPACE;
                end
                else if (ch == CODE_NLINE_ESC)
                begin
                    esc_after = ESC_NLINE;
                end
                else if (ch == CODE_FORM_FEED)
                begin
                    oc        = ASCII_FF;
                    rep       = REPEAT_W'(1);
                    esc_after = ESC_SKIP;
                end
                else if (ch != CODE_NULL)
                begin
                    oc  = ch;
                    rep = REPEAT_W'(1);
                end
            end
        endcase
        // Nothing printed means the character field reads as zero.
        if (rep == '0)
        begin
            oc = '0;
        end
    end

    assign emit = (rep != '0) || s_axis_tlast;

    // Next state: a record end restores the start-of-record state.
    always_comb
    begin
        esc_next = esc_reg;
        pos_next = pos_reg;
        ok_next  = ok_reg;
        if (in_fire)
        begin
            if (s_axis_tlast)
            begin
                esc_next = ESC_NONE;
                pos_next = '0;
                ok_next  = 1'b1;
            end
            else
            begin
                esc_next = esc_after;
                pos_next = pos_now;
                ok_next  = ok_now;
            end
        end
    end

    // Result register load.
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        repeat_next    = repeat_reg;
        eoj_next       = eoj_reg;
        done_next      = done_reg;
        if (in_fire && emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = oc;
            repeat_next    = rep;
            eoj_next       = s_axis_tlast && ok_now && (pos_now >= MIN_EOJ_LEN);
            done_next      = s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= ESC_NONE;
            pos_reg       <= '0;
            ok_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            esc_reg       <= esc_next;
            pos_reg       <= pos_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        repeat_reg   <= repeat_next;
        eoj_reg      <= eoj_next;
        done_reg     <= done_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - OUT_CHAR_W - REPEAT_W){1'b0}}, repeat_reg, out_char_reg};
    assign m_axis_tuser  = eoj_reg;
    assign m_axis_tlast  = done_reg;

    // A result that does not end a record always prints something.
    a_mid_record_prints: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (repeat_reg != '0))
        else $error("mid-record result with zero repeat count");

    // End of job is only reported on a record's last result.
    a_eoj_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("end of job outside record end");

    // A zero repeat count carries a zero character.
    a_zero_rep_char: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (repeat_reg == '0)) |-> (out_char_reg == '0))
        else $error("nonzero character with zero repeat count");

    // A record end leaves the decoder at the start-of-record state.
    a_record_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=> (esc_reg == ESC_NONE && pos_reg == '0 && ok_reg))
        else $error("decoder state not cleared after record end");

    // Every record end produces a result in the next cycle.
    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("record end without result");

endmodule

`default_nettype wire
